// ===== hw/rtl/lfs_pkg.sv =====
// Package for the line follower steering block: field widths, position codes,
// request payload structs and the threshold vector type.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package lfs_pkg;

  localparam int NumSens  = 8;
  localparam int SampleW  = 10;
  localparam int PctW     = 7;
  localparam int PosW     = 3;
  localparam int PatW     = NumSens;
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  localparam logic [SampleW-1:0] ThrReset = SampleW'(350);

  // position classes
  localparam logic [PosW-1:0] PosMid   = 3'd0;
  localparam logic [PosW-1:0] PosLeft  = 3'd1;
  localparam logic [PosW-1:0] PosRight = 3'd2;
  localparam logic [PosW-1:0] PosFull  = 3'd3;
  localparam logic [PosW-1:0] PosBlank = 3'd4;

  // one threshold per sensor, sensor 0 at index 0
  typedef logic [NumSens-1:0][SampleW-1:0] thr_vec_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_s0;
    logic [SampleW-1:0] sample_s1;
    logic [SampleW-1:0] sample_s2;
    logic [SampleW-1:0] sample_s3;
    logic [SampleW-1:0] sample_s4;
    logic [SampleW-1:0] sample_s5;
    logic [SampleW-1:0] sample_s6;
    logic [SampleW-1:0] sample_s7;
  } in_item_t;

  typedef struct packed {
    logic [PctW-1:0] left_pct;
    logic [PctW-1:0] right_pct;
    logic [PosW-1:0] position_class;
    logic [PatW-1:0] line_pattern;
    logic            in_corner;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfs_cfg_regs.sv =====
// APB-style register file holding the eight sensor thresholds.
// Depends on lfs_pkg for widths and the threshold vector type.
`default_nettype none

module lfs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lfs_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [lfs_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic      [lfs_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                               cfg_pready,
  output lfs_pkg::thr_vec_t                  thr
);

  localparam int IdxW = $clog2(lfs_pkg::NumSens);

  lfs_pkg::thr_vec_t thr_r;
  logic              wr_en;
  logic [IdxW-1:0]   reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[IdxW+1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // threshold write, one word per register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lfs_pkg::NumSens; i++) begin
        thr_r[i] <= lfs_pkg::ThrReset;
      end
    end else if (wr_en) begin
      thr_r[reg_idx] <= cfg_pwdata[lfs_pkg::SampleW-1:0];
    end
  end

  // read back, zero extended
  assign cfg_prdata = lfs_pkg::CfgDataW'(thr_r[reg_idx]);
  assign thr        = thr_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lfs_steer_core.sv =====
// Steering decision: pattern table, kept position/corner/crossing state and
// speed ratio selection. Depends on lfs_pkg for codes and the result struct.
`default_nettype none

module lfs_steer_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        advance,
  input  wire logic [lfs_pkg::PatW-1:0]    pattern,
  output lfs_pkg::out_item_t               result
);

  localparam int PctW = lfs_pkg::PctW;
  localparam int PosW = lfs_pkg::PosW;
  localparam int PatW = lfs_pkg::PatW;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            corner_r, corner_nxt;
  logic            cross_r, cross_nxt;
  logic [PatW-1:0] last_pat_r;
  logic [PctW-1:0] left_r, left_nxt;
  logic [PctW-1:0] right_r, right_nxt;

  // pattern table, then speed choice from the resulting position
  always_comb begin
    pos_nxt    = pos_r;
    corner_nxt = corner_r;
    cross_nxt  = cross_r;
    left_nxt   = left_r;
    right_nxt  = right_r;

    unique case (pattern)
      8'h10, 8'h08, 8'h18, 8'h38, 8'h1C: pos_nxt = lfs_pkg::PosMid;
      8'h30, 8'h60, 8'hC0, 8'h80: begin
        if (!corner_r) pos_nxt = lfs_pkg::PosRight;
      end
      8'h0C, 8'h06, 8'h03, 8'h01: begin
        if (!corner_r) pos_nxt = lfs_pkg::PosLeft;
      end
      8'h00: pos_nxt = lfs_pkg::PosBlank;
      8'hFF, 8'h7F: begin
        corner_nxt = 1'b0;
        pos_nxt    = lfs_pkg::PosFull;
      end
      8'hF0, 8'hF8: cross_nxt = 1'b0;
      8'h0F, 8'h1F: cross_nxt = 1'b1;
      default: ;
    endcase

    priority if (pos_nxt == lfs_pkg::PosMid) begin
      corner_nxt = 1'b0;
      priority if (pattern == 8'h08) begin
        left_nxt = 7'd100; right_nxt = 7'd90;
      end else if (pattern == 8'h10) begin
        left_nxt = 7'd90;  right_nxt = 7'd100;
      end else if (pattern == 8'h18) begin
        left_nxt = 7'd100; right_nxt = 7'd100;
      end else begin
      end
    end else if (pos_nxt == lfs_pkg::PosRight) begin
      corner_nxt = 1'b0;
      priority if (pattern == 8'h30) begin
        left_nxt = 7'd70; right_nxt = 7'd90;
      end else if (pattern == 8'h60) begin
        left_nxt = 7'd55; right_nxt = 7'd80;
      end else if (pattern == 8'hC0) begin
        left_nxt = 7'd30; right_nxt = 7'd70;
      end else if (pattern == 8'h80) begin
        left_nxt = 7'd20; right_nxt = 7'd70;
      end else begin
      end
    end else if (pos_nxt == lfs_pkg::PosLeft) begin
      corner_nxt = 1'b0;
      priority if (pattern == 8'h0C) begin
        left_nxt = 7'd90; right_nxt = 7'd70;
      end else if (pattern == 8'h06) begin
        left_nxt = 7'd80; right_nxt = 7'd55;
      end else if (pattern == 8'h03) begin
        left_nxt = 7'd70; right_nxt = 7'd30;
      end else if (pattern == 8'h01) begin
        left_nxt = 7'd70; right_nxt = 7'd20;
      end else begin
      end
    end else if (pos_nxt == lfs_pkg::PosBlank) begin
      // lost the line: turn toward the side it was last seen on
      priority if (last_pat_r == 8'hC0 || last_pat_r == 8'hE0 ||
                   last_pat_r == 8'hF0 || last_pat_r == 8'hF8) begin
        corner_nxt = 1'b1;
        left_nxt   = 7'd0;
        right_nxt  = 7'd80;
      end else if (last_pat_r == 8'h03 || last_pat_r == 8'h07 ||
                   last_pat_r == 8'h0F || last_pat_r == 8'h1F) begin
        corner_nxt = 1'b1;
        left_nxt   = 7'd80;
        right_nxt  = 7'd0;
      end else if (last_pat_r == 8'h18 || last_pat_r == 8'h10 ||
                   last_pat_r == 8'h08) begin
        left_nxt  = 7'd100;
        right_nxt = 7'd100;
      end else begin
      end
    end else if (pos_nxt == lfs_pkg::PosFull) begin
      if (cross_nxt) begin
        left_nxt = 7'd80; right_nxt = 7'd0;
      end else begin
        left_nxt = 7'd0;  right_nxt = 7'd80;
      end
    end else begin
    end
  end

  // state advances once per request handed to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= lfs_pkg::PosMid;
      corner_r   <= 1'b0;
      cross_r    <= 1'b0;
      last_pat_r <= '0;
      left_r     <= '0;
      right_r    <= '0;
    end else if (advance) begin
      pos_r      <= pos_nxt;
      corner_r   <= corner_nxt;
      cross_r    <= cross_nxt;
      last_pat_r <= pattern;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
    end
  end

  assign result.left_pct       = left_nxt;
  assign result.right_pct      = right_nxt;
  assign result.position_class = pos_nxt;
  assign result.line_pattern   = pattern;
  assign result.in_corner      = corner_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/line_follower_steering.sv =====
// Line follower steering block, top level.
// Path: input register, then result register; thresholding and table decode fit between the two.
// Throughput: one request per cycle while the result stage is free (no result waiting, or out_stall low).
// A new request is taken while a result waits as long as the input register is free.
// Reset (rst_n, synchronous): thresholds to 350, position middle, flags and speeds to 0.
`default_nettype none

module line_follower_steering (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // sample requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lfs_pkg::in_item_t             in_data,
  // result requests
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lfs_pkg::out_item_t                 out_data,
  // configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lfs_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [lfs_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic      [lfs_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                               cfg_pready
);

  lfs_pkg::thr_vec_t                       thr;
  lfs_pkg::thr_vec_t                       samples;
  lfs_pkg::in_item_t                       in_q_r;
  logic                                    in_q_valid_r;
  lfs_pkg::out_item_t                      out_q_r;
  logic                                    out_q_valid_r;
  lfs_pkg::out_item_t                      result;
  logic [lfs_pkg::PatW-1:0]                pattern;
  logic                                    out_free;
  logic                                    advance;
  logic                                    in_take;

  lfs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  // handshake: result stage frees when empty or taken
  assign out_free = !out_q_valid_r || !out_stall;
  assign advance  = in_q_valid_r && out_free;
  assign in_stall = in_q_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (in_take) begin
      in_q_valid_r <= 1'b1;
    end else if (advance) begin
      in_q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_r <= in_data;
    end
  end

  // threshold compare, sensor 0 lands in the pattern MSB
  assign samples[0] = in_q_r.sample_s0;
  assign samples[1] = in_q_r.sample_s1;
  assign samples[2] = in_q_r.sample_s2;
  assign samples[3] = in_q_r.sample_s3;
  assign samples[4] = in_q_r.sample_s4;
  assign samples[5] = in_q_r.sample_s5;
  assign samples[6] = in_q_r.sample_s6;
  assign samples[7] = in_q_r.sample_s7;

  always_comb begin
    for (int i = 0; i < lfs_pkg::NumSens; i++) begin
      pattern[lfs_pkg::NumSens-1-i] = samples[i] > thr[i];
    end
  end

  lfs_steer_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .pattern (pattern),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_q_valid_r <= 1'b0;
    end else if (out_free) begin
      out_q_valid_r <= in_q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q_r <= result;
    end
  end

  assign out_valid = out_q_valid_r;
  assign out_data  = out_q_r;

endmodule

`default_nettype wire

// ===== tb/line_follower_steering_tb.sv =====
// Self-checking testbench for line_follower_steering: thresholds set over the APB port,
// sample requests checked against an in-bench steering predictor.
// Depends on lfs_pkg and the line_follower_steering RTL only.
`default_nettype none

module line_follower_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  line_follower_steering dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // request queues and counters
  in_item_t  sample_req_q[$];
  out_item_t steer_expected_q[$];
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;
  int        req_accepted = 0;
  int        res_checked = 0;
  int        mismatches = 0;
  int        settings_run = 0;

  // predictor state: thresholds as written, plus the steering registers
  logic [SampleW-1:0] thr_model[NumSens];
  logic [PosW-1:0]    pos_q = PosMid;
  logic               corner_q = 1'b0;
  logic               cross_right_q = 1'b0;
  logic [PatW-1:0]    prev_pattern = '0;
  logic [PctW-1:0]    left_q = '0;
  logic [PctW-1:0]    right_q = '0;

  function automatic out_item_t steer_predict(input in_item_t req);
    logic [SampleW-1:0] s[NumSens];
    logic [PatW-1:0]    pat;
    logic [PatW-1:0]    prev;
    out_item_t          res;
    s = '{req.sample_s0, req.sample_s1, req.sample_s2, req.sample_s3,
          req.sample_s4, req.sample_s5, req.sample_s6, req.sample_s7};
    prev = prev_pattern;
    pat = '0;
    for (int i = 0; i < NumSens; i++)
      if (s[i] > thr_model[i]) pat[NumSens-1-i] = 1'b1;

    // pattern decode; side classes are held while a corner is in progress
    case (pat)
      8'h10, 8'h08, 8'h18, 8'h38, 8'h1C: pos_q = PosMid;
      8'h30, 8'h60, 8'hC0, 8'h80: if (!corner_q) pos_q = PosRight;
      8'h0C, 8'h06, 8'h03, 8'h01: if (!corner_q) pos_q = PosLeft;
      8'h00: pos_q = PosBlank;
      8'hFF, 8'h7F: begin
        corner_q = 1'b0;
        pos_q = PosFull;
      end
      8'hF0, 8'hF8: cross_right_q = 1'b0;
      8'h0F, 8'h1F: cross_right_q = 1'b1;
      default: ;
    endcase

    // speed selection from the (possibly held) position
    case (pos_q)
      PosMid: begin
        corner_q = 1'b0;
        case (pat)
          8'h08: begin left_q = 7'd100; right_q = 7'd90; end
          8'h10: begin left_q = 7'd90; right_q = 7'd100; end
          8'h18: begin left_q = 7'd100; right_q = 7'd100; end
          default: ;
        endcase
      end
      PosRight: begin
        corner_q = 1'b0;
        case (pat)
          8'h30: begin left_q = 7'd70; right_q = 7'd90; end
          8'h60: begin left_q = 7'd55; right_q = 7'd80; end
          8'hC0: begin left_q = 7'd30; right_q = 7'd70; end
          8'h80: begin left_q = 7'd20; right_q = 7'd70; end
          default: ;
        endcase
      end
      PosLeft: begin
        corner_q = 1'b0;
        case (pat)
          8'h0C: begin left_q = 7'd90; right_q = 7'd70; end
          8'h06: begin left_q = 7'd80; right_q = 7'd55; end
          8'h03: begin left_q = 7'd70; right_q = 7'd30; end
          8'h01: begin left_q = 7'd70; right_q = 7'd20; end
          default: ;
        endcase
      end
      PosBlank: begin
        // line lost: turn toward the side it was last seen on
        if (prev == 8'hC0 || prev == 8'hE0 || prev == 8'hF0 || prev == 8'hF8) begin
          corner_q = 1'b1;
          left_q = 7'd0;
          right_q = 7'd80;
        end else if (prev == 8'h03 || prev == 8'h07 || prev == 8'h0F || prev == 8'h1F) begin
          corner_q = 1'b1;
          left_q = 7'd80;
          right_q = 7'd0;
        end else if (prev == 8'h18 || prev == 8'h10 || prev == 8'h08) begin
          left_q = 7'd100;
          right_q = 7'd100;
        end
      end
      PosFull: begin
        if (cross_right_q) begin left_q = 7'd80; right_q = 7'd0; end
        else begin left_q = 7'd0; right_q = 7'd80; end
      end
      default: ;
    endcase
    prev_pattern = pat;

    res.left_pct       = left_q;
    res.right_pct      = right_q;
    res.position_class = pos_q;
    res.line_pattern   = pat;
    res.in_corner      = corner_q;
    return res;
  endfunction

  // sample driver: holds a request until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        steer_expected_q.push_back(steer_predict(in_data));
        req_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= sample_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        res_checked++;
        if (steer_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          mismatches++;
        end else begin
          want = steer_expected_q.pop_front();
          if (out_data.left_pct !== want.left_pct) begin
            $display("%0t: left_pct expected %0d got %0d", $time, want.left_pct,
                     out_data.left_pct);
            mismatches++;
          end
          if (out_data.right_pct !== want.right_pct) begin
            $display("%0t: right_pct expected %0d got %0d", $time, want.right_pct,
                     out_data.right_pct);
            mismatches++;
          end
          if (out_data.position_class !== want.position_class) begin
            $display("%0t: position_class expected %0d got %0d", $time,
                     want.position_class, out_data.position_class);
            mismatches++;
          end
          if (out_data.line_pattern !== want.line_pattern) begin
            $display("%0t: line_pattern expected %h got %h", $time, want.line_pattern,
                     out_data.line_pattern);
            mismatches++;
          end
          if (out_data.in_corner !== want.in_corner) begin
            $display("%0t: in_corner expected %0d got %0d", $time, want.in_corner,
                     out_data.in_corner);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // APB write followed by a read back of the same threshold
  task automatic write_threshold(input int idx, input logic [SampleW-1:0] val);
    logic [CfgDataW-1:0] junk;
    junk = $urandom_range(1) ? $urandom : '0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrW'(idx * 4);
    cfg_pwdata  <= {junk[CfgDataW-1:SampleW], val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    thr_model[idx] = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CfgDataW'(val)) begin
      $display("%0t: threshold %0d read expected %0d got %0d", $time, idx, val, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // samples that threshold to the wanted pattern, favoring the compare edges
  function automatic in_item_t make_item(input logic [PatW-1:0] pat);
    logic [SampleW-1:0] s[NumSens];
    logic [SampleW-1:0] t;
    in_item_t           req;
    for (int i = 0; i < NumSens; i++) begin
      t = thr_model[i];
      if (pat[NumSens-1-i] && t != '1) begin
        case ($urandom_range(2))
          0: s[i] = t + 1'b1;
          1: s[i] = '1;
          default: s[i] = SampleW'($urandom_range(1023, t + 1));
        endcase
      end else begin
        case ($urandom_range(2))
          0: s[i] = t;
          1: s[i] = '0;
          default: s[i] = SampleW'($urandom_range(t, 0));
        endcase
      end
    end
    req.sample_s0 = s[0]; req.sample_s1 = s[1]; req.sample_s2 = s[2];
    req.sample_s3 = s[3]; req.sample_s4 = s[4]; req.sample_s5 = s[5];
    req.sample_s6 = s[6]; req.sample_s7 = s[7];
    return req;
  endfunction

  function automatic logic [PatW-1:0] pick4(input logic [PatW-1:0] a, b, c, d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic logic [PatW-1:0] track_pattern();
    case ($urandom_range(3))
      0: return ($urandom_range(4) == 0) ? 8'h38 : pick4(8'h10, 8'h08, 8'h18, 8'h1C);
      1: return pick4(8'h30, 8'h60, 8'hC0, 8'h80);
      2: return pick4(8'h0C, 8'h06, 8'h03, 8'h01);
      default: return PatW'($urandom_range(255));
    endcase
  endfunction

  task automatic push_pattern(input logic [PatW-1:0] pat, inout int n);
    sample_req_q.push_back(make_item(pat));
    n++;
  endtask

  // random track episodes: corners, crossings, tracking, line loss and noise
  task automatic queue_episodes(input int total);
    int n;
    n = 0;
    while (n < total) begin
      case ($urandom_range(9))
        0, 1: begin
          push_pattern(pick4(8'hC0, 8'hE0, 8'hF0, 8'hF8), n);
          repeat ($urandom_range(3, 1)) push_pattern(8'h00, n);
          repeat ($urandom_range(3)) push_pattern(track_pattern(), n);
        end
        2, 3: begin
          push_pattern(pick4(8'h03, 8'h07, 8'h0F, 8'h1F), n);
          repeat ($urandom_range(3, 1)) push_pattern(8'h00, n);
          repeat ($urandom_range(3)) push_pattern(track_pattern(), n);
        end
        4: begin
          push_pattern(pick4(8'hF0, 8'hF8, 8'h0F, 8'h1F), n);
          repeat ($urandom_range(2, 1)) push_pattern(pick4(8'hFF, 8'h7F, 8'hFF, 8'h00), n);
        end
        5, 6: repeat ($urandom_range(6, 2)) push_pattern(track_pattern(), n);
        7: begin
          push_pattern(pick4(8'h10, 8'h08, 8'h18, 8'h38), n);
          push_pattern(8'h00, n);
        end
        8: begin
          sample_req_q.push_back(in_item_t'(80'({$urandom, $urandom, $urandom})));
          n++;
        end
        default: push_pattern(PatW'($urandom_range(255)), n);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (sample_req_q.size() != 0 || in_valid || steer_expected_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("[line_follower_steering] ERROR");
    $finish;
  end

  initial begin
    logic [PatW-1:0] directed[$];
    logic [SampleW-1:0] v;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int i = 0; i < NumSens; i++) thr_model[i] = ThrReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      // idle profile: receiver-heavy, then sender-heavy, then none
      sender_idle_pct    = (ph < 2) ? 30 : (ph < 4) ? 73 : 0;
      receiver_stall_pct = (ph < 2) ? 73 : (ph < 4) ? 30 : 0;
      for (int i = 0; i < NumSens; i++) begin
        case (ph)
          0: v = ThrReset;
          2: v = '0;
          3: v = '1;
          4: case ($urandom_range(3))
               0: v = '0;
               1: v = '1;
               2: v = ThrReset;
               default: v = SampleW'($urandom_range(1023));
             endcase
          default: v = SampleW'($urandom_range(1023));
        endcase
        write_threshold(i, v);
      end
      settings_run++;
      @(negedge clk);

      if (ph == 0) begin
        // sample extremes, then every table entry but 8'hF0, and the corner/crossing cases
        sample_req_q.push_back('0);
        sample_req_q.push_back('1);
        directed = '{8'h08, 8'h10, 8'h18, 8'h38, 8'h1C, 8'h30, 8'h60, 8'hC0, 8'h00,
                     8'h80, 8'h0C, 8'hFF, 8'h0F, 8'h1F, 8'h7F, 8'hF8, 8'h03, 8'h00,
                     8'h06, 8'h01, 8'h18, 8'h00, 8'h5A};
        foreach (directed[k]) sample_req_q.push_back(make_item(directed[k]));
      end
      queue_episodes(108);
      wait_drained();
    end

    if (steer_expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, steer_expected_q.size());
      mismatches++;
    end
    $display("covered %0d sample requests and %0d results over %0d threshold settings",
             req_accepted, res_checked, settings_run);
    if (mismatches == 0) begin
      $display("[line_follower_steering] OK");
    end else begin
      $display("[line_follower_steering] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
